// ===== hw/rtl/afr_pkg.sv =====
// Package for the API frame receiver: codes, widths and the result type.
package afr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned StatW  = 2;
  localparam int unsigned PhaseW = 3;

  localparam logic [ByteW-1:0] StartByte = 8'h7E;
  localparam logic [ByteW-1:0] SumGood   = 8'hFF;
  localparam logic [LenW-1:0]  LimitRst  = 16'hFFFF;

  typedef enum logic [StatW-1:0] {
    StNone   = 2'd0,
    StGood   = 2'd1,
    StBadSum = 2'd2,
    StBadLen = 2'd3
  } status_e;

  typedef struct packed {
    status_e          status;
    logic             payload_valid;
    logic [ByteW-1:0] payload_byte;
    logic [LenW-1:0]  payload_index;
    logic [ByteW-1:0] frame_kind;
    logic [LenW-1:0]  payload_length;
  } afr_result_t;

endpackage

// ===== hw/rtl/afr_if.sv =====
// Handshake interfaces for the received byte and the result channels.
interface afr_in_if;
  import afr_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afr_res_if;
  import afr_pkg::*;
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic             payload_valid;
  logic [ByteW-1:0] payload_byte;
  logic [LenW-1:0]  payload_index;
  logic [ByteW-1:0] frame_kind;
  logic [LenW-1:0]  payload_length;
  modport source (output valid, output status, output payload_valid, output payload_byte,
                  output payload_index, output frame_kind, output payload_length,
                  input ready);
  modport sink   (input valid, input status, input payload_valid, input payload_byte,
                  input payload_index, input frame_kind, input payload_length,
                  output ready);
endinterface

// ===== hw/rtl/afr_parser.sv =====
// Frame parser: phase register, length, checksum and type state, per-byte result.
module afr_parser import afr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LenW-1:0]  cfg_wdata_i,
  input  logic             accept_i,
  input  logic [ByteW-1:0] rx_byte_i,
  output afr_result_t      result_o
);

  localparam logic [PhaseW-1:0] PhIdle    = 3'd0;
  localparam logic [PhaseW-1:0] PhLenHi   = 3'd1;
  localparam logic [PhaseW-1:0] PhLenLo   = 3'd2;
  localparam logic [PhaseW-1:0] PhType    = 3'd3;
  localparam logic [PhaseW-1:0] PhPayload = 3'd4;
  localparam logic [PhaseW-1:0] PhCheck   = 3'd5;

  logic [LenW-1:0]   limit_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [LenW-1:0]   pos_q, pos_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0]  kind_q, kind_d;

  logic [LenW-1:0]   new_len;
  logic [LenW-1:0]   pos_inc;
  logic [ByteW-1:0]  sum_add;

  assign new_len = {pos_q[ByteW-1:0], rx_byte_i};
  assign pos_inc = pos_q + LenW'(1);
  assign sum_add = sum_q + rx_byte_i;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    len_d    = len_q;
    sum_d    = sum_q;
    kind_d   = kind_q;
    result_o = '0;
    result_o.status = StNone;
    if (rx_byte_i == StartByte) begin
      phase_d = PhLenHi;
      sum_d   = '0;
      len_d   = '0;
      pos_d   = '0;
    end else begin
      unique case (phase_q)
        PhIdle: ;
        PhLenHi: begin
          pos_d   = {{(LenW-ByteW){1'b0}}, rx_byte_i};
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          pos_d = '0;
          if (new_len == '0 || new_len > limit_q) begin
            result_o.status = StBadLen;
            len_d   = '0;
            phase_d = PhIdle;
          end else begin
            len_d   = new_len;
            phase_d = PhType;
          end
        end
        PhType: begin
          kind_d  = rx_byte_i;
          sum_d   = rx_byte_i;
          pos_d   = '0;
          phase_d = (len_q <= LenW'(1)) ? PhCheck : PhPayload;
        end
        PhPayload: begin
          result_o.payload_valid = 1'b1;
          result_o.payload_byte  = rx_byte_i;
          result_o.payload_index = pos_q;
          sum_d = sum_add;
          pos_d = pos_inc;
          if (len_q == '0 || pos_inc >= len_q - LenW'(1)) begin
            phase_d = PhCheck;
          end
        end
        PhCheck: begin
          sum_d = sum_add;
          result_o.status = (sum_add == SumGood) ? StGood : StBadSum;
          phase_d = PhIdle;
        end
        default: phase_d = PhIdle;
      endcase
    end
    result_o.frame_kind     = kind_d;
    result_o.payload_length = (len_d == '0) ? '0 : len_d - LenW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitRst;
      phase_q <= PhIdle;
      pos_q   <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      kind_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        len_q   <= len_d;
        sum_q   <= sum_d;
        kind_q  <= kind_d;
      end
    end
  end

endmodule

// ===== hw/rtl/afr_out_reg.sv =====
// Result register: holds one finished result until the sink takes it.
module afr_out_reg import afr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  afr_result_t result_i,
  output logic        space_o,
  afr_res_if.source   res_o
);

  logic        valid_q, valid_d;
  afr_result_t data_q;

  assign space_o = !valid_q || res_o.ready;
  assign valid_d = load_i || (valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign res_o.valid          = valid_q;
  assign res_o.status         = data_q.status;
  assign res_o.payload_valid  = data_q.payload_valid;
  assign res_o.payload_byte   = data_q.payload_byte;
  assign res_o.payload_index  = data_q.payload_index;
  assign res_o.frame_kind     = data_q.frame_kind;
  assign res_o.payload_length = data_q.payload_length;

endmodule

// ===== hw/rtl/api_frame_receiver.sv =====
// Top level of the API frame receiver.
// Takes one received byte per transaction and returns one result per byte: status of the
// frame (good, bad checksum, bad length), payload bytes with their index, the frame type
// and the payload length; results are registered. A new byte is accepted every cycle
// unless stalled: input ready drops only while the result register holds a result the
// sink has not taken. The byte 0x7E always restarts parsing. length_limit may be written
// through cfg_we_i/cfg_wdata_i while the block is idle; it resets to 65535.
module api_frame_receiver import afr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  afr_in_if.sink          rx_i,
  afr_res_if.source       res_o
);

  logic        accept;
  logic        space;
  afr_result_t result;

  assign rx_i.ready = space;
  assign accept     = rx_i.valid && space;

  afr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .rx_byte_i   (rx_i.rx_byte),
    .result_o    (result)
  );

  afr_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (result),
    .space_o  (space),
    .res_o    (res_o)
  );

endmodule
